>>> src/first_fit_heap_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Clocked, reset-qualified property wrappers.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// check a property on every clock outside reset
`define FFHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check an implication on every clock outside reset
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int DEF_HEAP_BYTES = 65536;
    localparam int HDR_BYTES      = 8;
    localparam int SPLIT_MIN      = HDR_BYTES + 8;
    localparam int MIN_HEAP       = 64;

    localparam int SZ_W       = 17;
    localparam int OFF_W      = 17;
    localparam int NEED_W     = 18;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;
    localparam int PADDR_W    = 3;

    localparam logic [OFF_W-1:0] NULL_OFF = '1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_OOM   = 2'd1;
    localparam logic [1:0] STAT_DFREE = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_SIZE = 1'b1;

endpackage

>>> src/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// Address-ordered free list allocator with block split and neighbor merge.
//
//   channel | dir | beat contents
//   s_      | in  | tuser: op; tdata: req_size, free_addr
//   m_      | out | tdata: status, addr
//   apb     | in  | heap_base at 0x0, heap_size at 0x4
//
// One request at a time. Each free block visited takes a read of the size and
// link memories (RD) and an evaluate (EV). A free first reads the block header
// (FHDR), and a merge on both sides adds a read and evaluate of the next block
// (NXRD, NXEV); a successful request then runs the WR write slots before DONE.
// The memory read port sets the walk rate. After reset and after each register
// write, the INIT state rebuilds the single free block; s_tready stays low
// meanwhile. A stalled m_ beat holds the finished request in its last state.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // req_size[16:0], free_addr[48:17]
    input  logic                 s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // status[1:0], addr[33:2]
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int SLOTS = HEAP_BYTES / 4;
    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 2);
    localparam int HEAP_CAP = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
    localparam logic [SZ_W-1:0] HSIZE_RST = SZ_W'(HEAP_CAP & ~3);
    localparam logic [SZ_W-1:0] HSIZE_MAX = SZ_W'(HEAP_BYTES & ~3);

    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_FHDR = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_EV   = 4'd4;
    localparam logic [3:0] ST_NXRD = 4'd5;
    localparam logic [3:0] ST_NXEV = 4'd6;
    localparam logic [3:0] ST_WR   = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    typedef struct packed {
        logic             se;
        logic [IW-1:0]    sa;
        logic [SZ_W-1:0]  sd;
        logic             ne;
        logic [IW-1:0]    na;
        logic [OFF_W-1:0] nd;
    } wop_t;

    function automatic logic [IW-1:0] idx(input logic [OFF_W-1:0] o);
        return IW'(o >> 2);
    endfunction

    logic [3:0]        state_reg, state_next;
    logic [31:0]       base_reg, base_next;
    logic [SZ_W-1:0]   hsize_reg, hsize_next;
    logic [OFF_W-1:0]  head_reg, head_next;
    logic [OFF_W-1:0]  cur_reg, cur_next;
    logic [OFF_W-1:0]  prev_reg, prev_next;
    logic              pnull_reg, pnull_next;
    logic [OFF_W-1:0]  nx_reg, nx_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [SZ_W-1:0]   bsz_reg, bsz_next;
    logic [SZ_W-1:0]   acc_reg, acc_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [CW-1:0]     n_reg, n_next;
    logic              op_reg, op_next;
    wop_t              wop_reg [0:2];
    wop_t              wop_next [0:2];
    logic [1:0]        wk_reg, wk_next;
    logic [1:0]        rstat_reg, rstat_next;
    logic [31:0]       raddr_reg, raddr_next;
    logic              mval_reg, mval_next;
    logic [1:0]        mstat_reg, mstat_next;
    logic [31:0]       maddr_reg, maddr_next;

    logic              sz_we, nx_we;
    logic [IW-1:0]     sz_waddr, nx_waddr, rd_addr;
    logic [SZ_W-1:0]   sz_wdata, sz_rdata;
    logic [OFF_W-1:0]  nx_wdata, nx_rdata;

    logic              cfg_wr;
    logic [SZ_W-1:0]   cfg_size;
    logic [16:0]       req;
    logic [31:0]       faddr, off32;
    logic [NEED_W-1:0] need_in;
    logic              split;
    wop_t              wop_none;

    ffha_ram #(.WIDTH(SZ_W), .DEPTH(SLOTS)) u_size_ram (
        .aclk(aclk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
        .raddr(rd_addr), .rdata(sz_rdata)
    );

    ffha_ram #(.WIDTH(OFF_W), .DEPTH(SLOTS)) u_next_ram (
        .aclk(aclk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(rd_addr), .rdata(nx_rdata)
    );

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_SIZE) ? {15'd0, hsize_reg} : base_reg;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = {6'd0, maddr_reg, mstat_reg};
    assign req      = s_tdata[16:0];
    assign faddr    = s_tdata[48:17];
    assign off32    = faddr - base_reg - 32'(HDR_BYTES);
    assign need_in  = ((NEED_W'(req) + NEED_W'(3)) & ~NEED_W'(3)) + NEED_W'(HDR_BYTES);
    assign split    = {1'b0, sz_rdata} >= ({1'b0, need_reg} + 19'(SPLIT_MIN));
    assign wop_none = '0;

    always_comb begin
        cfg_size = pwdata[SZ_W-1:0] & ~SZ_W'(3);
        if (cfg_size < SZ_W'(MIN_HEAP)) begin
            cfg_size = SZ_W'(MIN_HEAP);
        end else if (32'(cfg_size) > 32'(HEAP_BYTES)) begin
            cfg_size = HSIZE_MAX;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE: rd_addr = idx(off32[OFF_W-1:0]);
            ST_NXRD: rd_addr = idx(nx_reg);
            default: rd_addr = idx(cur_reg);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        hsize_next = hsize_reg;
        head_next  = head_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        pnull_next = pnull_reg;
        nx_next    = nx_reg;
        off_next   = off_reg;
        bsz_next   = bsz_reg;
        acc_next   = acc_reg;
        need_next  = need_reg;
        n_next     = n_reg;
        op_next    = op_reg;
        wop_next   = wop_reg;
        wk_next    = wk_reg;
        rstat_next = rstat_reg;
        raddr_next = raddr_reg;
        mval_next  = mval_reg & ~m_tready;
        mstat_next = mstat_reg;
        maddr_next = maddr_reg;
        sz_we      = 1'b0;
        sz_waddr   = '0;
        sz_wdata   = '0;
        nx_we      = 1'b0;
        nx_waddr   = '0;
        nx_wdata   = '0;

        unique case (state_reg)
            ST_INIT: begin
                sz_we      = 1'b1;
                sz_wdata   = hsize_reg;
                nx_we      = 1'b1;
                nx_wdata   = NULL_OFF;
                head_next  = '0;
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    pnull_next = 1'b1;
                    cur_next   = head_reg;
                    n_next     = '0;
                    raddr_next = '0;
                    wop_next   = '{wop_none, wop_none, wop_none};
                    wk_next    = '0;
                    if (s_tuser == OP_ALLOC) begin
                        need_next = need_in;
                        if (head_reg == NULL_OFF) begin
                            rstat_next = STAT_OOM;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_RD;
                        end
                    end else begin
                        off_next = off32[OFF_W-1:0];
                        if (off32[1:0] != 2'd0 || off32 >= {15'd0, hsize_reg}) begin
                            rstat_next = STAT_DFREE;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_FHDR;
                        end
                    end
                end
            end
            ST_FHDR: begin
                bsz_next = sz_rdata;
                if (sz_rdata < SZ_W'(HDR_BYTES) || sz_rdata[1:0] != 2'd0
                        || sz_rdata > hsize_reg - off_reg) begin
                    rstat_next = STAT_DFREE;
                    state_next = ST_DONE;
                end else if (head_reg == NULL_OFF) begin
                    head_next   = off_reg;
                    wop_next[0] = '{se: 1'b0, sa: '0, sd: '0, ne: 1'b1,
                                    na: idx(off_reg), nd: NULL_OFF};
                    rstat_next  = STAT_OK;
                    state_next  = ST_WR;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_EV;
            end
            ST_EV: begin
                if (op_reg == OP_ALLOC) begin
                    if ({1'b0, sz_rdata} >= need_reg) begin
                        if (split) begin
                            wop_next[0] = '{se: 1'b1, sa: idx(cur_reg + OFF_W'(need_reg)),
                                            sd: sz_rdata - SZ_W'(need_reg), ne: 1'b1,
                                            na: idx(cur_reg + OFF_W'(need_reg)), nd: nx_rdata};
                            nx_next     = cur_reg + OFF_W'(need_reg);
                        end else begin
                            nx_next     = nx_rdata;
                        end
                        wop_next[1] = '{se: split, sa: idx(cur_reg), sd: SZ_W'(need_reg),
                                        ne: 1'b1, na: idx(cur_reg), nd: NULL_OFF};
                        wop_next[2] = '{se: 1'b0, sa: '0, sd: '0, ne: ~pnull_reg,
                                        na: idx(prev_reg),
                                        nd: split ? cur_reg + OFF_W'(need_reg) : nx_rdata};
                        if (pnull_reg) begin
                            head_next = split ? cur_reg + OFF_W'(need_reg) : nx_rdata;
                        end
                        rstat_next = STAT_OK;
                        raddr_next = base_reg + 32'(cur_reg) + 32'(HDR_BYTES);
                        state_next = ST_WR;
                    end else begin
                        prev_next  = cur_reg;
                        pnull_next = 1'b0;
                        cur_next   = nx_rdata;
                        n_next     = n_reg + CW'(1);
                        if (nx_rdata == NULL_OFF || n_reg >= CW'(SLOTS)) begin
                            rstat_next = STAT_OOM;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_RD;
                        end
                    end
                end else begin
                    if (cur_reg == off_reg || nx_rdata == off_reg) begin
                        rstat_next = STAT_DFREE;
                        state_next = ST_DONE;
                    end else if ({1'b0, cur_reg} + {1'b0, sz_rdata} == {1'b0, off_reg}) begin
                        acc_next   = sz_rdata + bsz_reg;
                        rstat_next = STAT_OK;
                        if ({1'b0, cur_reg} + {1'b0, sz_rdata + bsz_reg} == {1'b0, nx_rdata}) begin
                            nx_next    = nx_rdata;
                            state_next = ST_NXRD;
                        end else begin
                            wop_next[0] = '{se: 1'b1, sa: idx(cur_reg), sd: sz_rdata + bsz_reg,
                                            ne: 1'b0, na: '0, nd: '0};
                            state_next  = ST_WR;
                        end
                    end else if (cur_reg > off_reg) begin
                        wop_next[0] = '{se: ({1'b0, off_reg} + {1'b0, bsz_reg} == {1'b0, cur_reg}),
                                        sa: idx(off_reg), sd: bsz_reg + sz_rdata, ne: 1'b1,
                                        na: idx(off_reg),
                                        nd: ({1'b0, off_reg} + {1'b0, bsz_reg} == {1'b0, cur_reg})
                                            ? nx_rdata : cur_reg};
                        wop_next[2] = '{se: 1'b0, sa: '0, sd: '0, ne: ~pnull_reg,
                                        na: idx(prev_reg), nd: off_reg};
                        if (pnull_reg) begin
                            head_next = off_reg;
                        end
                        rstat_next = STAT_OK;
                        state_next = ST_WR;
                    end else begin
                        prev_next  = cur_reg;
                        pnull_next = 1'b0;
                        cur_next   = nx_rdata;
                        n_next     = n_reg + CW'(1);
                        if (nx_rdata == NULL_OFF || n_reg >= CW'(SLOTS)) begin
                            wop_next[0] = '{se: 1'b0, sa: '0, sd: '0, ne: 1'b1,
                                            na: idx(off_reg), nd: NULL_OFF};
                            wop_next[2] = '{se: 1'b0, sa: '0, sd: '0, ne: 1'b1,
                                            na: idx(cur_reg), nd: off_reg};
                            rstat_next  = STAT_OK;
                            state_next  = ST_WR;
                        end else begin
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_NXRD: begin
                state_next = ST_NXEV;
            end
            ST_NXEV: begin
                wop_next[0] = '{se: 1'b1, sa: idx(cur_reg), sd: acc_reg + sz_rdata,
                                ne: 1'b1, na: idx(cur_reg), nd: nx_rdata};
                state_next  = ST_WR;
            end
            ST_WR: begin
                sz_we    = wop_reg[wk_reg].se;
                sz_waddr = wop_reg[wk_reg].sa;
                sz_wdata = wop_reg[wk_reg].sd;
                nx_we    = wop_reg[wk_reg].ne;
                nx_waddr = wop_reg[wk_reg].na;
                nx_wdata = wop_reg[wk_reg].nd;
                wk_next  = wk_reg + 2'd1;
                if (wk_reg == 2'd2) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mstat_next = rstat_reg;
                    maddr_next = (rstat_reg == STAT_OK) ? raddr_reg : 32'd0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase

        if (cfg_wr) begin
            if (paddr[2] == REG_BASE) begin
                base_next = pwdata;
            end else begin
                hsize_next = cfg_size;
            end
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            base_reg  <= '0;
            hsize_reg <= HSIZE_RST;
            head_reg  <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            hsize_reg <= hsize_next;
            head_reg  <= head_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        pnull_reg <= pnull_next;
        nx_reg    <= nx_next;
        off_reg   <= off_next;
        bsz_reg   <= bsz_next;
        acc_reg   <= acc_next;
        need_reg  <= need_next;
        n_reg     <= n_next;
        op_reg    <= op_next;
        wop_reg   <= wop_next;
        wk_reg    <= wk_next;
        rstat_reg <= rstat_next;
        raddr_reg <= raddr_next;
        mstat_reg <= mstat_next;
        maddr_reg <= maddr_next;
    end

endmodule

>>> src/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_core_assert.svh"

module ffha_checker
    import ffha_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `FFHA_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "m_ beat dropped")
    `FFHA_ASSERT_IMP(a_stat_code, m_tvalid, m_tdata[1:0] != STAT_BAD, "bad status code")
    `FFHA_ASSERT_IMP(a_addr_zero, m_tvalid && m_tdata[1:0] != STAT_OK, m_tdata[33:2] == 32'd0, "addr set on failure")
    `FFHA_ASSERT(a_one_req, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_heap_allocator_core. A directed table of
// alloc and free requests runs from reset, then several heap settings are
// written over APB and random traffic runs against an in-bench model of the
// free list. It mixes allocs, frees of live blocks, double frees and bad
// addresses, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb;
    import ffha_pkg::*;

    localparam int unsigned SLOTS     = 16384;
    localparam int unsigned LIST_END  = 32'hFFFF_FFFF;
    localparam int          IDLE_MAX  = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr;
    } result_t;

    typedef struct {
        logic        op;
        logic [16:0] req;
        logic [31:0] fa;
        bit          fixed;
        logic [1:0]  status;
        logic [31:0] addr;
    } row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    first_fit_heap_allocator_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // free list mirror
    int unsigned heap_base;
    int unsigned heap_size;
    int unsigned list_head;
    int unsigned blk_size [SLOTS];
    int unsigned blk_next [SLOTS];

    result_t     pending_q[$];
    logic [31:0] live_q[$];
    logic [31:0] freed_q[$];

    bit                   s_beat;
    bit                   m_beat;
    logic [M_TDATA_W-1:0] m_sample;
    int                   mismatches;
    int                   idle_cycles;
    int                   burst_left;
    bit                   gaps_on;
    int                   stall_mode;
    int                   cyc;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned size_at(int unsigned off);
        return (off >> 2) < SLOTS ? blk_size[off >> 2] : 0;
    endfunction

    function automatic int unsigned next_at(int unsigned off);
        return (off >> 2) < SLOTS ? blk_next[off >> 2] : LIST_END;
    endfunction

    function automatic void put_size(int unsigned off, int unsigned v);
        if ((off >> 2) < SLOTS) blk_size[off >> 2] = v;
    endfunction

    function automatic void put_next(int unsigned off, int unsigned v);
        if ((off >> 2) < SLOTS) blk_next[off >> 2] = v;
    endfunction

    function automatic void relink(int unsigned prv, int unsigned target);
        if (prv == LIST_END) list_head = target;
        else put_next(prv, target);
    endfunction

    function automatic void rebuild_heap();
        list_head = 0;
        put_size(0, heap_size);
        put_next(0, LIST_END);
        live_q.delete();
        freed_q.delete();
    endfunction

    function automatic result_t alloc_block(logic [16:0] req);
        int unsigned need, prv, cur, n, sz, nx, rest;
        result_t     r;
        need = ((int'(req) + 3) & ~3) + HDR_BYTES;
        prv  = LIST_END;
        cur  = list_head;
        r    = '{STAT_OOM, 32'd0};
        for (n = 0; cur != LIST_END && n <= SLOTS; n++) begin
            sz = size_at(cur);
            nx = next_at(cur);
            if (sz >= need) begin
                if (sz >= need + HDR_BYTES + 8) begin
                    rest = cur + need;
                    put_size(rest, sz - need);
                    put_next(rest, nx);
                    put_size(cur, need);
                    nx = rest;
                end
                put_next(cur, LIST_END);
                relink(prv, nx);
                r = '{STAT_OK, heap_base + cur + HDR_BYTES};
                return r;
            end
            prv = cur;
            cur = nx;
        end
        return r;
    endfunction

    function automatic logic [1:0] release_block(logic [31:0] fa);
        int unsigned off, bsz, prv, cur, n, nx, sz;
        off = fa - heap_base - HDR_BYTES;
        prv = LIST_END;
        cur = list_head;
        if ((off & 3) != 0 || off >= heap_size) return STAT_DFREE;
        bsz = size_at(off);
        if (bsz < HDR_BYTES || (bsz & 3) != 0 || bsz > heap_size - off) return STAT_DFREE;
        for (n = 0; cur != LIST_END && n <= SLOTS; n++) begin
            nx = next_at(cur);
            sz = size_at(cur);
            if (cur == off || nx == off) return STAT_DFREE;
            if (cur + sz == off) begin
                sz += bsz;
                if (cur + sz == nx) begin
                    sz += size_at(nx);
                    put_next(cur, next_at(nx));
                end
                put_size(cur, sz);
                return STAT_OK;
            end
            if (cur > off) begin
                relink(prv, off);
                put_next(off, cur);
                if (off + bsz == cur) begin
                    put_size(off, bsz + sz);
                    put_next(off, nx);
                end
                return STAT_OK;
            end
            prv = cur;
            cur = nx;
        end
        relink(prv, off);
        put_next(off, LIST_END);
        return STAT_OK;
    endfunction

    function automatic result_t serve_request(logic op, logic [16:0] req, logic [31:0] fa);
        result_t r;
        if (op == OP_ALLOC) begin
            r = alloc_block(req);
            if (r.status == STAT_OK) live_q.push_back(r.addr);
        end else begin
            r = '{release_block(fa), 32'd0};
        end
        return r;
    endfunction

    task automatic apb_write(logic reg_sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(reg_sel));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_BASE) begin
            heap_base = value;
        end else begin
            heap_size = value[16:0] & ~17'd3;
            if (heap_size < MIN_HEAP) heap_size = MIN_HEAP;
            if (heap_size > DEF_HEAP_BYTES) heap_size = DEF_HEAP_BYTES;
        end
        rebuild_heap();
        @(posedge aclk);
    endtask

    task automatic send_beat(logic op, logic [16:0] req, logic [31:0] fa,
                             bit fixed, result_t fixed_res);
        result_t r;
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, fa, req};
        do @(posedge aclk); while (!s_beat);
        r = serve_request(op, req, fa);
        pending_q.push_back(fixed ? fixed_res : r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_item();
        int          r, k;
        logic [16:0] req;
        logic [31:0] fa;
        r   = $urandom_range(0, 99);
        req = $urandom_range(0, 17'h1FFFF);
        fa  = $urandom();
        if (live_q.size() == 0 || r < 50) begin
            k = $urandom_range(0, 99);
            if (k < 70)      req = $urandom_range(0, 64);
            else if (k < 90) req = $urandom_range(0, 1024);
            else if (k < 97) req = $urandom_range(0, heap_size);
            send_beat(OP_ALLOC, req, fa, 0, '0);
        end else if (r < 88) begin
            k  = $urandom_range(0, live_q.size() - 1);
            fa = live_q[k];
            live_q.delete(k);
            freed_q.push_back(fa);
            send_beat(OP_FREE, req, fa, 0, '0);
        end else if (r < 93 && freed_q.size() != 0) begin
            fa = freed_q[$urandom_range(0, freed_q.size() - 1)];
            send_beat(OP_FREE, req, fa, 0, '0);
        end else if (r < 97) begin
            if (((fa - heap_base - HDR_BYTES) & 3) == 0) fa ^= 32'd1;
            send_beat(OP_FREE, req, fa, 0, '0);
        end else begin
            fa = heap_base + HDR_BYTES + heap_size + 4 * $urandom_range(0, 1000);
            send_beat(OP_FREE, req, fa, 0, '0);
        end
    endtask

    always @(negedge aclk) begin
        s_beat   = s_tvalid && s_tready;
        m_beat   = m_tvalid && m_tready;
        m_sample = m_tdata;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 99) < 70);
            default: m_tready <= ((cyc % 9) < 3);
        endcase
        if (aresetn && m_beat) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_sample);
            end else begin
                result_t e;
                e = pending_q.pop_front();
                if (m_sample[1:0] !== e.status || m_sample[33:2] !== e.addr) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d addr %h, got status %0d addr %h",
                                 e.status, e.addr, m_sample[1:0], m_sample[33:2]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_beat || m_beat) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_MAX) begin
                $display("FAIL first_fit_heap_allocator_core");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    row_t rows[$];

    initial begin
        int i, p;
        rows = '{
            '{OP_ALLOC, 17'd0,       32'd0,          1, STAT_OK,    32'd8},
            '{OP_ALLOC, 17'd1,       32'd0,          1, STAT_OK,    32'd16},
            '{OP_ALLOC, 17'h10000,   32'd0,          1, STAT_OOM,   32'd0},
            '{OP_ALLOC, 17'h1FFFF,   32'hFFFF_FFFF,  1, STAT_OOM,   32'd0},
            '{OP_FREE,  17'h1FFFF,   32'd8,          1, STAT_OK,    32'd0},
            '{OP_FREE,  17'd0,       32'd8,          1, STAT_DFREE, 32'd0},
            '{OP_FREE,  17'd0,       32'd3,          1, STAT_DFREE, 32'd0},
            '{OP_FREE,  17'd0,       32'h0001_0008,  1, STAT_DFREE, 32'd0},
            '{OP_FREE,  17'd0,       32'hFFFF_FFFF,  1, STAT_DFREE, 32'd0},
            '{OP_ALLOC, 17'd0,       32'd0,          1, STAT_OK,    32'd8},
            '{OP_FREE,  17'd0,       32'd16,         1, STAT_OK,    32'd0},
            '{OP_ALLOC, 17'd5,       32'd0,          1, STAT_OK,    32'd16},
            '{OP_FREE,  17'd0,       32'd8,          0, STAT_OK,    32'd0},
            '{OP_FREE,  17'd0,       32'd16,         0, STAT_OK,    32'd0},
            '{OP_ALLOC, 17'd65528,   32'd0,          0, STAT_OK,    32'd0},
            '{OP_ALLOC, 17'd0,       32'd0,          0, STAT_OK,    32'd0},
            '{OP_FREE,  17'd0,       32'd8,          0, STAT_OK,    32'd0},
            '{OP_ALLOC, 17'd100,     32'd0,          0, STAT_OK,    32'd0},
            '{OP_ALLOC, 17'd100,     32'd0,          0, STAT_OK,    32'd0},
            '{OP_ALLOC, 17'd100,     32'd0,          0, STAT_OK,    32'd0},
            '{OP_FREE,  17'd0,       32'd232,        0, STAT_OK,    32'd0},
            '{OP_FREE,  17'd0,       32'd8,          0, STAT_OK,    32'd0},
            '{OP_FREE,  17'd0,       32'd120,        0, STAT_OK,    32'd0}
        };
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        m_tready    <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        gaps_on     = 0;
        stall_mode  = 0;
        cyc         = 0;
        heap_base   = 0;
        heap_size   = DEF_HEAP_BYTES;
        for (i = 0; i < SLOTS; i++) begin
            blk_size[i] = 0;
            blk_next[i] = 0;
        end
        rebuild_heap();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            send_beat(rows[i].op, rows[i].req, rows[i].fa, rows[i].fixed,
                      '{rows[i].status, rows[i].addr});
        drain();

        for (p = 0; p < 7; p++) begin
            case (p)
                0: begin apb_write(REG_BASE, 32'h0000_1000); apb_write(REG_SIZE, 32'd64); end
                1: begin apb_write(REG_SIZE, 32'h0001_FFFF); apb_write(REG_BASE, 32'hFFFF_FF00); end
                2: begin apb_write(REG_BASE, 32'd0); apb_write(REG_SIZE, 32'd5); end
                3: begin apb_write(REG_BASE, $urandom()); apb_write(REG_SIZE, 32'd65536); end
                4: begin apb_write(REG_SIZE, 32'd2047); end
                5: begin apb_write(REG_BASE, $urandom()); apb_write(REG_SIZE, $urandom_range(64, 8192)); end
                default: begin apb_write(REG_BASE, 32'hFFFF_FFFF); apb_write(REG_SIZE, 32'd512); end
            endcase
            gaps_on    = (p % 3) != 2;
            stall_mode = $urandom_range(0, 2);
            repeat (55) random_item();
            drain();
        end

        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("PASS first_fit_heap_allocator_core");
        end else begin
            $display("FAIL first_fit_heap_allocator_core");
        end
        $finish;
    end

endmodule
